// ===== hw/rtl/rotating_taiji_pixel_shader_macros.svh =====
// Assertion shorthands used by the checker file of the shader.
`ifndef ROTATING_TAIJI_PIXEL_SHADER_MACROS_SVH
`define ROTATING_TAIJI_PIXEL_SHADER_MACROS_SVH

// Check a property on every rising edge outside reset.
`define RTPS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("rotating taiji shader: property violated");

// Check a property on every rising edge, reset included.
`define RTPS_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("rotating taiji shader: property violated");

`endif

// ===== hw/rtl/rtps_pkg.sv =====
package rtps_pkg;

	// Field widths
	localparam int PIXEL_X_W  = 10;
	localparam int PIXEL_Y_W  = 9;
	localparam int ADDR_W     = 19;
	localparam int COLOUR_W   = 24;
	localparam int CENTRE_X_W = 10;
	localparam int CENTRE_Y_W = 9;
	localparam int RADIUS_W   = 9;
	localparam int ANGLE_W    = 9;

	// Raster line length used for the framebuffer address
	localparam int SCREEN_WIDTH = 800;

	// Trig table format
	localparam int TRIG_FRACTION_BITS_DEF = 14;
	localparam int TRIG_FRACTION_MAX      = 16;
	localparam int QUARTER_W              = TRIG_FRACTION_MAX + 1;
	localparam int QUARTER_N              = 91;
	localparam int QIDX_W                 = 7;

	// Datapath widths: signed offsets from the centre, rotated offsets, shifted offsets
	localparam int DELTA_W = 11;
	localparam int U_W     = 13;
	localparam int V_W     = 14;

	// Configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 10;

	localparam logic [CFG_INDEX_W-1:0] REG_CENTRE_X     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTRE_Y     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_OUTER_RADIUS = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_LOBE_RADIUS  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DOT_RADIUS   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_STEP   = 3'd5;

	localparam logic [CENTRE_X_W-1:0] CENTRE_X_RST     = 10'd400;
	localparam logic [CENTRE_Y_W-1:0] CENTRE_Y_RST     = 9'd240;
	localparam logic [RADIUS_W-1:0]   OUTER_RADIUS_RST = 9'd100;
	localparam logic [RADIUS_W-1:0]   LOBE_RADIUS_RST  = 9'd50;
	localparam logic [RADIUS_W-1:0]   DOT_RADIUS_RST   = 9'd15;
	localparam logic [ANGLE_W-1:0]    ANGLE_STEP_RST   = 9'd5;

	// Angles in degrees
	localparam logic [ANGLE_W-1:0] QUARTER_TURN       = 9'd90;
	localparam logic [ANGLE_W-1:0] HALF_TURN          = 9'd180;
	localparam logic [ANGLE_W-1:0] THREE_QUARTER_TURN = 9'd270;
	localparam logic [ANGLE_W-1:0] FULL_TURN          = 9'd360;

	// Colours
	localparam logic [COLOUR_W-1:0] COL_WHITE = 24'hFFFFFF;
	localparam logic [COLOUR_W-1:0] COL_BLACK = 24'h000000;
	localparam logic [COLOUR_W-1:0] COL_RED   = 24'hFF0000;

	// Pi in Q30
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	typedef struct packed {
		logic [PIXEL_X_W-1:0] pixel_x;
		logic [PIXEL_Y_W-1:0] pixel_y;
		logic                 frame_end;
	} pix_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   pixel_address;
		logic [COLOUR_W-1:0] pixel_colour;
	} res_t;

	typedef logic [QUARTER_N-1:0][QUARTER_W-1:0] quarter_tab_t;

	// Quarter-wave sine, 0..90 degrees, rounded half up to frac_bits fraction bits.
	// Built at elaboration from a Q30 Taylor series with terms up to x^15.
	function automatic quarter_tab_t quarter_table(input int frac_bits);
		quarter_tab_t      tab;
		logic [63:0]        x;
		logic [63:0]        term;
		logic [63:0]        mag;
		logic signed [63:0] sum;
		tab = '0;
		for (int k = 0; k < QUARTER_N; k++) begin
			x    = 64'(k) * PI_Q30 / 64'(HALF_TURN);
			term = x;
			sum  = signed'(x);
			for (int n = 1; n <= 7; n++) begin
				term = ((((term * x) >> 30) * x) >> 30) / 64'((2 * n) * (2 * n + 1));
				if ((n % 2) == 1)
					sum = sum - signed'(term);
				else
					sum = sum + signed'(term);
			end
			if (sum < 0)
				sum = '0;
			mag    = unsigned'(sum);
			tab[k] = QUARTER_W'(((mag >> (29 - frac_bits)) + 64'd1) >> 1);
		end
		return tab;
	endfunction

endpackage

// ===== hw/rtl/rotating_taiji_pixel_shader.sv =====
// Rotating taiji shader: one pixel coordinate in, one framebuffer address and colour out,
// one pixel per clock sustained while the result side does not stall. A pixel accepted on
// pix_valid/pix_stall appears on res_valid after passing the nine-stage pipeline (capture,
// fold angle, sine/cosine lookup, four rotation products, sums, truncation, lobe offsets,
// squares, circle tests). Bubbles in the pipeline close up under back-pressure, so
// pix_stall only rises when every stage holds a pixel and the result is stalled. The beat
// carrying frame_end is drawn with the old angle; the next pixel sees the advanced one.
// Registers (cfg_index 0..5): centre x, centre y, outer, lobe and dot radius, angle step;
// cfg_ready is always high and writes are meant for an idle shader.
module rotating_taiji_pixel_shader #(
	parameter int TRIG_FRACTION_BITS = rtps_pkg::TRIG_FRACTION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pix_valid,
	output logic                               pix_stall,
	input  rtps_pkg::pix_t                     pix_data,
	output logic                               res_valid,
	input  logic                               res_stall,
	output rtps_pkg::res_t                     res_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rtps_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [rtps_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rtps_pkg::*;

	localparam int TW     = TRIG_FRACTION_BITS + 2;
	localparam int PW     = DELTA_W + TW;
	localparam int ACC_W  = PW + 2;
	localparam int RSQ_W  = 2 * RADIUS_W;
	localparam int USQ_W  = 2 * U_W;
	localparam int VSQ_W  = 2 * V_W;
	localparam int SUM_W  = VSQ_W + 1;
	localparam quarter_tab_t QTAB = quarter_table(TRIG_FRACTION_BITS);
	localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'((1 << TRIG_FRACTION_BITS) - 1);

	// Configuration and angle state
	logic [CENTRE_X_W-1:0] centre_x_q;
	logic [CENTRE_Y_W-1:0] centre_y_q;
	logic [RADIUS_W-1:0]   outer_radius_q;
	logic [RADIUS_W-1:0]   lobe_radius_q;
	logic [RADIUS_W-1:0]   dot_radius_q;
	logic [ANGLE_W-1:0]    angle_step_q;
	logic [ANGLE_W-1:0]    angle_q;
	logic [ANGLE_W:0]      angle_sum;
	logic [RSQ_W-1:0]      r2_q;
	logic [RSQ_W-1:0]      l2_q;
	logic [RSQ_W-1:0]      d2_q;

	// Flow control
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;
	logic valid_s9;
	logic pix_accept;

	// Stage registers
	logic [PIXEL_X_W-1:0]     px_s1;
	logic [PIXEL_Y_W-1:0]     py_s1;
	logic [ANGLE_W-1:0]       angle_s1;

	logic [QIDX_W-1:0]        sin_idx, cos_idx;
	logic                     sin_neg, cos_neg;
	logic [QIDX_W-1:0]        sin_idx_s2, cos_idx_s2;
	logic                     sin_neg_s2, cos_neg_s2;
	logic signed [DELTA_W-1:0] dx_s2, dy_s2;
	logic [ADDR_W-1:0]        addr_s2;

	logic [TRIG_FRACTION_BITS:0] sin_mag, cos_mag;
	logic signed [TW-1:0]     sin_s3, cos_s3;
	logic signed [DELTA_W-1:0] dx_s3, dy_s3;
	logic [ADDR_W-1:0]        addr_s3;

	logic signed [PW-1:0]     p_xc_s4, p_ys_s4, p_xs_s4, p_yc_s4;
	logic [ADDR_W-1:0]        addr_s4;

	logic signed [ACC_W-1:0]  cx_scaled, cy_scaled;
	logic signed [ACC_W-1:0]  acc_x_s5, acc_y_s5;
	logic [ADDR_W-1:0]        addr_s5;

	logic signed [ACC_W-1:0]  tx, ty, qx, qy, ux, vy;
	logic signed [U_W-1:0]    u_s6, v_s6;
	logic [ADDR_W-1:0]        addr_s6;

	logic signed [U_W-1:0]    u_s7;
	logic signed [V_W-1:0]    v_s7, vp_s7, vm_s7;
	logic [ADDR_W-1:0]        addr_s7;

	logic signed [USQ_W-1:0]  sq_u;
	logic signed [VSQ_W-1:0]  sq_v, sq_vp, sq_vm;
	logic [USQ_W-1:0]         uu_s8;
	logic [VSQ_W-1:0]         vv_s8, vpp_s8, vmm_s8;
	logic                     u_le0_s8, u_ge0_s8;
	logic [ADDR_W-1:0]        addr_s8;

	logic [SUM_W-1:0]         whole, upper, lower;
	logic [COLOUR_W-1:0]      colour;
	res_t                     res_s9;

	// Register writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_x_q     <= CENTRE_X_RST;
			centre_y_q     <= CENTRE_Y_RST;
			outer_radius_q <= OUTER_RADIUS_RST;
			lobe_radius_q  <= LOBE_RADIUS_RST;
			dot_radius_q   <= DOT_RADIUS_RST;
			angle_step_q   <= ANGLE_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CENTRE_X:     centre_x_q     <= cfg_data[CENTRE_X_W-1:0];
				REG_CENTRE_Y:     centre_y_q     <= cfg_data[CENTRE_Y_W-1:0];
				REG_OUTER_RADIUS: outer_radius_q <= cfg_data[RADIUS_W-1:0];
				REG_LOBE_RADIUS:  lobe_radius_q  <= cfg_data[RADIUS_W-1:0];
				REG_DOT_RADIUS:   dot_radius_q   <= cfg_data[RADIUS_W-1:0];
				REG_ANGLE_STEP:   angle_step_q   <= cfg_data[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Squared radii, refreshed every cycle from the registers
	always_ff @(posedge clk) begin
		r2_q <= RSQ_W'(outer_radius_q) * RSQ_W'(outer_radius_q);
		l2_q <= RSQ_W'(lobe_radius_q) * RSQ_W'(lobe_radius_q);
		d2_q <= RSQ_W'(dot_radius_q) * RSQ_W'(dot_radius_q);
	end

	// Advance the angle on the last beat of a frame, wrap to zero at a full turn
	assign angle_sum = {1'b0, angle_q} + {1'b0, angle_step_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
		end else if (pix_accept && pix_data.frame_end) begin
			angle_q <= (angle_sum >= {1'b0, FULL_TURN}) ? '0 : angle_sum[ANGLE_W-1:0];
		end
	end

	// Stage enables: a stage loads when empty or when the next one moves
	assign en_s9 = !valid_s9 || !res_stall;
	assign en_s8 = !valid_s8 || en_s9;
	assign en_s7 = !valid_s7 || en_s8;
	assign en_s6 = !valid_s6 || en_s7;
	assign en_s5 = !valid_s5 || en_s6;
	assign en_s4 = !valid_s4 || en_s5;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;

	assign pix_stall  = !en_s1;
	assign pix_accept = pix_valid && en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= pix_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
			if (en_s6) valid_s6 <= valid_s5;
			if (en_s7) valid_s7 <= valid_s6;
			if (en_s8) valid_s8 <= valid_s7;
			if (en_s9) valid_s9 <= valid_s8;
		end
	end

	// Stage 1: capture the beat with the angle it is drawn at
	always_ff @(posedge clk) begin
		if (en_s1) begin
			px_s1    <= pix_data.pixel_x;
			py_s1    <= pix_data.pixel_y;
			angle_s1 <= angle_q;
		end
	end

	// Stage 2: fold the angle onto the quarter table for sine and cosine, take the offsets from the centre and the address
	always_comb begin
		if (angle_s1 <= QUARTER_TURN) begin
			sin_idx = QIDX_W'(angle_s1);
			sin_neg = 1'b0;
		end else if (angle_s1 < HALF_TURN) begin
			sin_idx = QIDX_W'(HALF_TURN - angle_s1);
			sin_neg = 1'b0;
		end else if (angle_s1 <= THREE_QUARTER_TURN) begin
			sin_idx = QIDX_W'(angle_s1 - HALF_TURN);
			sin_neg = 1'b1;
		end else begin
			sin_idx = QIDX_W'(FULL_TURN - angle_s1);
			sin_neg = 1'b1;
		end
	end

	always_comb begin
		if (angle_s1 < QUARTER_TURN) begin
			cos_idx = QIDX_W'(QUARTER_TURN - angle_s1);
			cos_neg = 1'b0;
		end else if (angle_s1 <= HALF_TURN) begin
			cos_idx = QIDX_W'(angle_s1 - QUARTER_TURN);
			cos_neg = 1'b1;
		end else if (angle_s1 < THREE_QUARTER_TURN) begin
			cos_idx = QIDX_W'(THREE_QUARTER_TURN - angle_s1);
			cos_neg = 1'b1;
		end else begin
			cos_idx = QIDX_W'(angle_s1 - THREE_QUARTER_TURN);
			cos_neg = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			sin_idx_s2 <= sin_idx;
			sin_neg_s2 <= sin_neg;
			cos_idx_s2 <= cos_idx;
			cos_neg_s2 <= cos_neg;
			dx_s2      <= $signed({1'b0, px_s1}) - $signed({1'b0, centre_x_q});
			dy_s2      <= $signed({2'b00, py_s1}) - $signed({2'b00, centre_y_q});
			addr_s2    <= ADDR_W'(px_s1) + ADDR_W'(py_s1) * ADDR_W'(SCREEN_WIDTH);
		end
	end

	// Stage 3: table read and sign
	assign sin_mag = QTAB[sin_idx_s2][TRIG_FRACTION_BITS:0];
	assign cos_mag = QTAB[cos_idx_s2][TRIG_FRACTION_BITS:0];

	always_ff @(posedge clk) begin
		if (en_s3) begin
			sin_s3  <= sin_neg_s2 ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
			cos_s3  <= cos_neg_s2 ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
			dx_s3   <= dx_s2;
			dy_s3   <= dy_s2;
			addr_s3 <= addr_s2;
		end
	end

	// Stage 4: rotation products
	always_ff @(posedge clk) begin
		if (en_s4) begin
			p_xc_s4 <= PW'(dx_s3) * PW'(cos_s3);
			p_ys_s4 <= PW'(dy_s3) * PW'(sin_s3);
			p_xs_s4 <= PW'(dx_s3) * PW'(sin_s3);
			p_yc_s4 <= PW'(dy_s3) * PW'(cos_s3);
			addr_s4 <= addr_s3;
		end
	end

	// Stage 5: sum the products and add back the scaled centre
	assign cx_scaled = ACC_W'(centre_x_q) << TRIG_FRACTION_BITS;
	assign cy_scaled = ACC_W'(centre_y_q) << TRIG_FRACTION_BITS;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			acc_x_s5 <= ACC_W'(p_xc_s4) - ACC_W'(p_ys_s4) + cx_scaled;
			acc_y_s5 <= ACC_W'(p_xs_s4) + ACC_W'(p_yc_s4) + cy_scaled;
			addr_s5  <= addr_s4;
		end
	end

	// Stage 6: drop the fraction toward zero, take the offset from the centre
	always_comb begin
		tx = acc_x_s5 + (acc_x_s5[ACC_W-1] ? ROUND_BIAS : '0);
		ty = acc_y_s5 + (acc_y_s5[ACC_W-1] ? ROUND_BIAS : '0);
		qx = tx >>> TRIG_FRACTION_BITS;
		qy = ty >>> TRIG_FRACTION_BITS;
		ux = qx - $signed(ACC_W'(centre_x_q));
		vy = qy - $signed(ACC_W'(centre_y_q));
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			u_s6    <= U_W'(ux);
			v_s6    <= U_W'(vy);
			addr_s6 <= addr_s5;
		end
	end

	// Stage 7: offsets to the two lobe centres
	always_ff @(posedge clk) begin
		if (en_s7) begin
			u_s7    <= u_s6;
			v_s7    <= V_W'(v_s6);
			vp_s7   <= V_W'(v_s6) + $signed(V_W'(lobe_radius_q));
			vm_s7   <= V_W'(v_s6) - $signed(V_W'(lobe_radius_q));
			addr_s7 <= addr_s6;
		end
	end

	// Stage 8: squares
	always_comb begin
		sq_u  = USQ_W'(u_s7) * USQ_W'(u_s7);
		sq_v  = VSQ_W'(v_s7) * VSQ_W'(v_s7);
		sq_vp = VSQ_W'(vp_s7) * VSQ_W'(vp_s7);
		sq_vm = VSQ_W'(vm_s7) * VSQ_W'(vm_s7);
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			uu_s8    <= unsigned'(sq_u);
			vv_s8    <= unsigned'(sq_v);
			vpp_s8   <= unsigned'(sq_vp);
			vmm_s8   <= unsigned'(sq_vm);
			u_le0_s8 <= u_s7[U_W-1] || (u_s7 == '0);
			u_ge0_s8 <= !u_s7[U_W-1];
			addr_s8  <= addr_s7;
		end
	end

	// Stage 9: circle tests, later matches override earlier ones
	always_comb begin
		whole  = SUM_W'(uu_s8) + SUM_W'(vv_s8);
		upper  = SUM_W'(uu_s8) + SUM_W'(vpp_s8);
		lower  = SUM_W'(uu_s8) + SUM_W'(vmm_s8);
		colour = COL_RED;
		if ((whole <= SUM_W'(r2_q)) && u_le0_s8)
			colour = COL_BLACK;
		if ((whole <= SUM_W'(r2_q)) && u_ge0_s8)
			colour = COL_WHITE;
		if ((upper <= SUM_W'(l2_q)) && u_le0_s8)
			colour = COL_WHITE;
		if ((lower <= SUM_W'(l2_q)) && u_ge0_s8)
			colour = COL_BLACK;
		if (upper <= SUM_W'(d2_q))
			colour = COL_BLACK;
		if (lower <= SUM_W'(d2_q))
			colour = COL_WHITE;
	end

	always_ff @(posedge clk) begin
		if (en_s9) begin
			res_s9.pixel_address <= addr_s8;
			res_s9.pixel_colour  <= colour;
		end
	end

	assign res_valid = valid_s9;
	assign res_data  = res_s9;

endmodule

// ===== hw/rtl/rtps_checker.sv =====
`include "rotating_taiji_pixel_shader_macros.svh"

module rtps_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           pix_stall,
	input logic           res_valid,
	input logic           res_stall,
	input rtps_pkg::res_t res_data
);
	import rtps_pkg::*;

	logic colour_ok;

	// Flag the three legal colours
	assign colour_ok = res_data.pixel_colour inside {COL_RED, COL_BLACK, COL_WHITE};

	// No result is offered while reset is held
	`RTPS_ASSERT_ALWAYS(a_no_result_in_reset, clk, !arst_n |-> !res_valid)

	// Input side only stalls when a finished result is itself held back
	`RTPS_ASSERT(a_stall_from_backpressure, clk, arst_n, pix_stall |-> res_valid && res_stall)

	// Every result is red, black or white
	`RTPS_ASSERT(a_colour_legal, clk, arst_n, res_valid |-> colour_ok)

	// A stalled result beat holds
	`RTPS_ASSERT(a_result_holds, clk, arst_n, res_valid && res_stall |=> res_valid && $stable(res_data))

endmodule

bind rotating_taiji_pixel_shader rtps_checker u_rtps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_stall (pix_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_data  (res_data)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import rtps_pkg::*;

	localparam int TRIG_F      = TRIG_FRACTION_BITS_DEF;
	localparam int SCREEN_H    = 480;
	localparam int X_TOP       = 2 ** PIXEL_X_W - 1;
	localparam int Y_TOP       = 2 ** PIXEL_Y_W - 1;
	localparam int PIPE_CYCLES = 9;
	localparam int SETTLE      = PIPE_CYCLES + 11;
	localparam int IDLE_LIMIT  = 1000;
	localparam int PHASE_BEATS = 116;

	typedef struct packed {
		pix_t pix;
		logic known;
		res_t want;
	} row_t;

	localparam res_t UNCHECKED = '0;

	// Directed rows; typed-in results hold for the reset setup, the later ones at any angle
	localparam row_t DIRECTED [21] = '{
		'{'{10'd400, 9'd240, 1'b0}, 1'b1, '{19'd192400, COL_BLACK}},
		'{'{10'd0, 9'd0, 1'b0}, 1'b1, '{19'd0, COL_RED}},
		'{'{10'd1023, 9'd511, 1'b0}, 1'b1, '{19'd409823, COL_RED}},
		'{'{10'd799, 9'd479, 1'b0}, 1'b1, '{19'd383999, COL_RED}},
		'{'{10'd400, 9'd190, 1'b0}, 1'b1, '{19'd152400, COL_BLACK}},
		'{'{10'd400, 9'd290, 1'b0}, 1'b1, '{19'd232400, COL_WHITE}},
		'{'{10'd350, 9'd240, 1'b0}, 1'b1, '{19'd192350, COL_BLACK}},
		'{'{10'd450, 9'd240, 1'b0}, 1'b1, '{19'd192450, COL_WHITE}},
		'{'{10'd400, 9'd225, 1'b0}, 1'b1, '{19'd180400, COL_WHITE}},
		'{'{10'd400, 9'd175, 1'b0}, 1'b1, '{19'd140400, COL_BLACK}},
		'{'{10'd400, 9'd340, 1'b0}, 1'b1, '{19'd272400, COL_BLACK}},
		'{'{10'd400, 9'd341, 1'b0}, 1'b1, '{19'd273200, COL_RED}},
		'{'{10'd400, 9'd240, 1'b1}, 1'b1, '{19'd192400, COL_BLACK}},
		'{'{10'd450, 9'd240, 1'b0}, 1'b0, UNCHECKED},
		'{'{10'd400, 9'd190, 1'b1}, 1'b0, UNCHECKED},
		'{'{10'd512, 9'd256, 1'b0}, 1'b0, UNCHECKED},
		'{'{10'd0, 9'd511, 1'b1}, 1'b0, UNCHECKED},
		'{'{10'd1023, 9'd0, 1'b0}, 1'b1, '{19'd1023, COL_RED}},
		'{'{10'd682, 9'd341, 1'b1}, 1'b0, UNCHECKED},
		'{'{10'd341, 9'd170, 1'b0}, 1'b0, UNCHECKED},
		'{'{10'd400, 9'd240, 1'b0}, 1'b1, '{19'd192400, COL_BLACK}}
	};

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   pix_valid;
	logic                   pix_stall;
	pix_t                   pix_data;
	logic                   res_valid;
	logic                   res_stall;
	res_t                   res_data;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Side band travelling with each pixel beat: typed-in result, if any
	logic row_known;
	res_t row_want;

	logic pix_beat, res_beat, cfg_beat;
	assign pix_beat = pix_valid === 1'b1 && pix_stall === 1'b0;
	assign res_beat = res_valid === 1'b1 && res_stall === 1'b0;
	assign cfg_beat = cfg_valid === 1'b1 && cfg_ready === 1'b1;

	// Shadow of the shader's registers and spin state
	logic [CENTRE_X_W-1:0] centre_x_q   = CENTRE_X_RST;
	logic [CENTRE_Y_W-1:0] centre_y_q   = CENTRE_Y_RST;
	logic [RADIUS_W-1:0]   outer_q      = OUTER_RADIUS_RST;
	logic [RADIUS_W-1:0]   lobe_q       = LOBE_RADIUS_RST;
	logic [RADIUS_W-1:0]   dot_q        = DOT_RADIUS_RST;
	logic [ANGLE_W-1:0]    angle_step_q = ANGLE_STEP_RST;
	logic [ANGLE_W-1:0]    spin_deg     = '0;

	longint sine_lut [0:359];
	res_t   pending_pixels [$];
	int     mismatches = 0;
	int     idle_cycles = 0;
	bit     calm = 1'b0;

	rotating_taiji_pixel_shader dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_data  (pix_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Build the sine table: Q30 Taylor series over a quarter turn, rounded half up
	initial begin : trig_setup
		longint unsigned rad, term, mag;
		longint          acc;
		longint          quarter [0:90];
		for (int k = 0; k <= QUARTER_TURN; k++) begin
			rad  = 64'(k) * PI_Q30 / 64'(HALF_TURN);
			term = rad;
			acc  = longint'(rad);
			for (int n = 1; n <= 7; n++) begin
				term = ((((term * rad) >> 30) * rad) >> 30) / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1)
					acc = acc - longint'(term);
				else
					acc = acc + longint'(term);
			end
			if (acc < 0)
				acc = 0;
			mag        = acc;
			quarter[k] = longint'(((mag >> (29 - TRIG_F)) + 64'd1) >> 1);
		end
		for (int a = 0; a < FULL_TURN; a++) begin
			if (a <= QUARTER_TURN)
				sine_lut[a] = quarter[a];
			else if (a < HALF_TURN)
				sine_lut[a] = quarter[HALF_TURN - a];
			else if (a <= THREE_QUARTER_TURN)
				sine_lut[a] = -quarter[a - HALF_TURN];
			else
				sine_lut[a] = -quarter[FULL_TURN - a];
		end
	end

	// Rotate the pixel about the centre and run the circle tests in order
	function automatic res_t shade_pixel(input pix_t p);
		int unsigned a;
		longint      sn, cs, one, px, py, cx, cy, dx, dy, u, v;
		longint      rr, ll, dd, uu, whole, upper, lower;
		res_t        r;
		a = spin_deg;
		if (a >= FULL_TURN)
			a = 0;
		sn  = sine_lut[a];
		cs  = sine_lut[(a + QUARTER_TURN) % FULL_TURN];
		one = longint'(1) << TRIG_F;
		px  = p.pixel_x;
		py  = p.pixel_y;
		cx  = centre_x_q;
		cy  = centre_y_q;
		dx  = px - cx;
		dy  = py - cy;
		u   = (dx * cs - dy * sn + cx * one) / one - cx;
		v   = (dx * sn + dy * cs + cy * one) / one - cy;
		rr  = outer_q;
		ll  = lobe_q;
		dd  = dot_q;
		uu    = u * u;
		whole = uu + v * v;
		upper = uu + (v + ll) * (v + ll);
		lower = uu + (v - ll) * (v - ll);
		r.pixel_colour = COL_RED;
		if (whole <= rr * rr && u <= 0) r.pixel_colour = COL_BLACK;
		if (whole <= rr * rr && u >= 0) r.pixel_colour = COL_WHITE;
		if (upper <= ll * ll && u <= 0) r.pixel_colour = COL_WHITE;
		if (lower <= ll * ll && u >= 0) r.pixel_colour = COL_BLACK;
		if (upper <= dd * dd) r.pixel_colour = COL_BLACK;
		if (lower <= dd * dd) r.pixel_colour = COL_WHITE;
		r.pixel_address = ADDR_W'(px + py * SCREEN_WIDTH);
		return r;
	endfunction

	task automatic flag_field(input string field, input logic [31:0] want_v,
			input logic [31:0] got_v);
		mismatches++;
		$error("%s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
	endtask

	// Track register writes, predict each pixel beat, check each result beat
	always @(posedge clk) begin : scoreboard
		res_t        want;
		int unsigned nxt;
		if (cfg_beat) begin
			case (cfg_index)
				REG_CENTRE_X:     centre_x_q   = cfg_data;
				REG_CENTRE_Y:     centre_y_q   = cfg_data[CENTRE_Y_W-1:0];
				REG_OUTER_RADIUS: outer_q      = cfg_data[RADIUS_W-1:0];
				REG_LOBE_RADIUS:  lobe_q       = cfg_data[RADIUS_W-1:0];
				REG_DOT_RADIUS:   dot_q        = cfg_data[RADIUS_W-1:0];
				REG_ANGLE_STEP:   angle_step_q = cfg_data[ANGLE_W-1:0];
				default: ;
			endcase
		end
		if (pix_beat) begin
			pending_pixels.push_back(row_known ? row_want : shade_pixel(pix_data));
			// frame end: this beat used the old angle, the next one sees the new
			if (pix_data.frame_end) begin
				nxt      = int'(spin_deg >= FULL_TURN ? '0 : spin_deg) + int'(angle_step_q);
				spin_deg = (nxt >= FULL_TURN) ? '0 : ANGLE_W'(nxt);
			end
		end
		if (res_beat) begin
			if (pending_pixels.size() == 0) begin
				mismatches++;
				$error("result beat with nothing expected: address 0x%0h",
					res_data.pixel_address);
			end else begin
				want = pending_pixels.pop_front();
				if (res_data.pixel_address !== want.pixel_address)
					flag_field("pixel_address", 32'(want.pixel_address),
						32'(res_data.pixel_address));
				if (res_data.pixel_colour !== want.pixel_colour)
					flag_field("pixel_colour", 32'(want.pixel_colour),
						32'(res_data.pixel_colour));
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || pix_beat || res_beat || cfg_beat) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result side: stall a random number of cycles before each beat
	initial begin : result_sink
		int hold;
		forever begin
			hold = calm ? 0 : $urandom_range(0, 10);
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!res_beat);
		end
	end

	task automatic send_pixel(input pix_t p, input logic known, input res_t want);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix_data  <= p;
		row_known <= known;
		row_want  <= want;
		do @(posedge clk); while (pix_stall !== 1'b0);
	endtask

	// Hold off the sender until every result is back, then let the pipe settle
	task automatic drain_pixels();
		pix_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		do @(posedge clk); while (cfg_ready !== 1'b1);
	endtask

	function automatic int near(input int centre, input int span, input int top);
		int v;
		v = centre + int'($urandom_range(0, 2 * span)) - span;
		if (v < 0)
			v = 0;
		if (v > top)
			v = top;
		return v;
	endfunction

	// One setting of the registers, then short frames of random pixels
	task automatic run_phase(input int cx, input int cy, input int outer, input int lobe,
			input int dot, input int step);
		int   span, left_in_frame, roll;
		pix_t p;
		drain_pixels();
		write_reg(REG_CENTRE_X, cx);
		write_reg(REG_CENTRE_Y, cy);
		write_reg(REG_OUTER_RADIUS, outer);
		write_reg(REG_LOBE_RADIUS, lobe);
		write_reg(REG_DOT_RADIUS, dot);
		write_reg(REG_ANGLE_STEP, step);
		cfg_valid <= 1'b0;
		span          = outer + 20;
		left_in_frame = 0;
		for (int i = 0; i < PHASE_BEATS; i++) begin
			if (i % 25 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (left_in_frame == 0)
				left_in_frame = $urandom_range(1, 6);
			roll = $urandom_range(0, 9);
			if (roll < 7) begin
				p.pixel_x = PIXEL_X_W'(near(cx, span, X_TOP));
				p.pixel_y = PIXEL_Y_W'(near(cy, span, Y_TOP));
			end else if (roll < 9) begin
				p.pixel_x = PIXEL_X_W'($urandom_range(0, SCREEN_WIDTH - 1));
				p.pixel_y = PIXEL_Y_W'($urandom_range(0, SCREEN_H - 1));
			end else begin
				p.pixel_x = PIXEL_X_W'($urandom_range(0, X_TOP));
				p.pixel_y = PIXEL_Y_W'($urandom_range(0, Y_TOP));
			end
			left_in_frame--;
			p.frame_end = (left_in_frame == 0);
			// drop in the odd stray or missing frame end
			if ($urandom_range(0, 19) == 0)
				p.frame_end = ~p.frame_end;
			send_pixel(p, 1'b0, UNCHECKED);
		end
	endtask

	initial begin : stimulus
		arst_n    <= 1'b0;
		pix_valid <= 1'b0;
		pix_data  <= '0;
		row_known <= 1'b0;
		row_want  <= UNCHECKED;
		cfg_valid <= 1'b0;
		cfg_index <= REG_CENTRE_X;
		cfg_data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows on the reset setup
		foreach (DIRECTED[i])
			send_pixel(DIRECTED[i].pix, DIRECTED[i].known, DIRECTED[i].want);

		// Reset values again, all zero, the extremes, quarter-turn steps,
		// steps of a full turn or more, a random setting, a final ordinary one
		run_phase(400, 240, 100, 50, 15, 5);
		run_phase(0, 0, 0, 0, 0, 0);
		run_phase(SCREEN_WIDTH - 1, SCREEN_H - 1, 511, 511, 511, 359);
		run_phase(200, 100, 300, 150, 40, 90);
		run_phase(400, 240, 100, 50, 15, 360);
		run_phase(600, 300, 60, 30, 10, 511);
		run_phase($urandom_range(0, SCREEN_WIDTH - 1), $urandom_range(0, SCREEN_H - 1),
			$urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 511),
			$urandom_range(0, 359));
		run_phase(400, 240, 120, 60, 20, 7);

		calm = 1'b0;
		drain_pixels();
		if (mismatches == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
